@@ sv/gspa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gspa_pkg;

  // pool size default
  localparam int unsigned POOL_SLOTS_DEF = 64;

  // fixed field widths of the stream payloads
  localparam int unsigned IDX_IN_W  = 7;
  localparam int unsigned GEN_W     = 32;
  localparam int unsigned GIDX_W    = 6;
  localparam int unsigned CNT_OUT_W = 7;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 56;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic load;    // capture the input beat
    logic lookup;  // pick the slot and read its state
    logic commit;  // execute, update state, load the result register
  } gspa_ctl_t;

endpackage

`default_nettype wire

@@ sv/gspa_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gspa_ctrl
  import gspa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  output logic      s_ready_o,
  output logic      m_valid_o,
  input  logic      m_ready_i,
  output gspa_ctl_t ctl_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOKUP = 2'd1;
  localparam logic [1:0] S_EXEC   = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       s_acc;
  logic       commit;

  assign s_ready_o = (state_q == S_IDLE);
  assign s_acc     = s_valid_i && s_ready_o;
  assign commit    = (state_q == S_EXEC) && (!out_valid_q || m_ready_i);
  assign m_valid_o = out_valid_q;

  assign ctl_o.load   = s_acc;
  assign ctl_o.lookup = (state_q == S_LOOKUP);
  assign ctl_o.commit = commit;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_acc) state_d = S_LOOKUP;
      end
      S_LOOKUP: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (commit) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // one item in flight: no new beat right after an accept
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_ready_o)
    else $error("input accepted while an item is in flight");

  // a result only appears from a commit
  a_result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EXEC))
    else $error("result raised outside execute");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_ready_i) |-> !commit)
    else $error("commit over a pending result");

endmodule

`default_nettype wire

@@ sv/gspa_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gspa_dpath
  import gspa_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = POOL_SLOTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gspa_ctl_t            ctl_i,
  input  logic [CMD_W-1:0]     cmd_i,
  input  logic [IDX_IN_W-1:0]  slot_index_i,
  input  logic [GEN_W-1:0]     handle_generation_i,
  output logic [M_TDATA_W-1:0] result_o
);

  localparam int unsigned IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(POOL_SLOTS + 1);
  localparam int unsigned CW    = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;
  localparam int unsigned GW    = (IDX_W > GIDX_W) ? IDX_W : GIDX_W;
  localparam int unsigned OW    = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(POOL_SLOTS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(POOL_SLOTS);
  localparam logic [CW-1:0]    IDX_LIM  = CW'(POOL_SLOTS);

  // captured input beat
  logic [CMD_W-1:0]    cmd_q;
  logic [IDX_IN_W-1:0] idx_q;
  logic [GEN_W-1:0]    hgen_q;

  // ring pointers, free count, first-lap marker
  logic [IDX_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0] free_q, free_d;
  logic             lap_q, lap_d;

  // memories: free ring and per-slot {active, generation}
  logic [IDX_W-1:0] ring_mem [POOL_SLOTS];
  logic [GEN_W:0]   slot_mem [POOL_SLOTS];
  logic [IDX_W-1:0] ring_rd_q;
  logic [GEN_W:0]   slot_rd_q;

  // selected slot and whether its entry has ever been written
  logic [IDX_W-1:0] sa_q, sa_d;
  logic             sv_q, sv_d;

  logic [CW-1:0]    idx_ext;
  logic             in_rng;
  logic [IDX_W-1:0] idx_addr, ring_sel;
  logic             old_act;
  logic [GEN_W-1:0] old_gen, new_gen;
  logic             acq_ok, rel_ok, chk_ok, ok;
  logic             slot_we, ring_we;
  logic [GEN_W:0]   slot_wdata;
  logic [CNT_W-1:0] act_cnt;
  logic [OW-1:0]    free_ext, act_ext;
  logic [GW-1:0]    gidx_ext;
  logic [GEN_W-1:0] ggen;
  logic [M_TDATA_W-1:0] result_q;

  // capture input
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q  <= cmd_i;
      idx_q  <= slot_index_i;
      hgen_q <= handle_generation_i;
    end
  end

  assign idx_ext  = CW'(idx_q);
  assign in_rng   = idx_ext < IDX_LIM;
  assign idx_addr = idx_ext[IDX_W-1:0];

  // ring read at head every cycle; before the head first wraps, the head itself serves as the slot index
  always_ff @(posedge clk_i) begin
    ring_rd_q <= ring_mem[head_q];
    if (ring_we) ring_mem[tail_q] <= sa_q;
  end

  assign ring_sel = lap_q ? ring_rd_q : head_q;
  assign sa_d     = (cmd_q == CMD_ACQUIRE) ? ring_sel : idx_addr;
  // slots are first acquired in index order, so slots below head have been written
  assign sv_d     = lap_q || (sa_d < head_q);

  // slot state read
  always_ff @(posedge clk_i) begin
    if (ctl_i.lookup) begin
      slot_rd_q <= slot_mem[sa_d];
      sa_q      <= sa_d;
      sv_q      <= sv_d;
    end
    if (slot_we) slot_mem[sa_q] <= slot_wdata;
  end

  assign old_act = sv_q && slot_rd_q[GEN_W];
  assign old_gen = sv_q ? slot_rd_q[GEN_W-1:0] : '0;
  assign new_gen = old_gen + 1'b1;

  // command outcome
  assign acq_ok = (cmd_q == CMD_ACQUIRE) && (free_q != '0);
  assign rel_ok = (cmd_q == CMD_RELEASE) && in_rng && old_act && (free_q != FULL_CNT);
  assign chk_ok = (cmd_q == CMD_CHECK) && in_rng && old_act && (old_gen == hgen_q);
  assign ok     = acq_ok || rel_ok || chk_ok;

  assign slot_we    = ctl_i.commit && (acq_ok || rel_ok);
  assign ring_we    = ctl_i.commit && rel_ok;
  assign slot_wdata = acq_ok ? {1'b1, new_gen} : {1'b0, old_gen};

  // pointer and count update
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    free_d = free_q;
    lap_d  = lap_q;
    if (acq_ok) begin
      head_d = (head_q == LAST_POS) ? '0 : head_q + 1'b1;
      lap_d  = lap_q || (head_q == LAST_POS);
      free_d = free_q - 1'b1;
    end else if (rel_ok) begin
      tail_d = (tail_q == LAST_POS) ? '0 : tail_q + 1'b1;
      free_d = free_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      free_q <= FULL_CNT;
      lap_q  <= 1'b0;
    end else if (ctl_i.commit) begin
      head_q <= head_d;
      tail_q <= tail_d;
      free_q <= free_d;
      lap_q  <= lap_d;
    end
  end

  // result packing
  assign act_cnt  = FULL_CNT - free_d;
  assign free_ext = OW'(free_d);
  assign act_ext  = OW'(act_cnt);
  assign gidx_ext = acq_ok ? GW'(sa_q) : '0;
  assign ggen     = acq_ok ? new_gen : '0;

  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) begin
      result_q <= {1'b0, (free_d == FULL_CNT), (free_d == '0),
                   act_ext[CNT_OUT_W-1:0], free_ext[CNT_OUT_W-1:0],
                   ggen, gidx_ext[GIDX_W-1:0], ok};
    end
  end

  assign result_o = result_q;

  // free count never exceeds the pool
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= FULL_CNT)
    else $error("free count above pool size");

  // empty or full ring means head and tail meet
  a_ptr_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_q == '0 || free_q == FULL_CNT) |-> (head_q == tail_q))
    else $error("head and tail apart on empty or full ring");

  // a granted slot takes one free slot
  a_acq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.commit && acq_ok) |=> (free_q == $past(free_q) - 1'b1))
    else $error("acquire did not decrement free count");

  // first-lap marker is sticky
  a_lap_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(lap_q))
    else $error("lap marker cleared");

endmodule

`default_nettype wire

@@ sv/generational_slot_pool_allocator_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  tdata (low bit up)                                  tuser
// s_axis    in   slot_index[6:0], handle_generation[38:7], pad        cmd[1:0]
// m_axis    out  ok, granted_index, granted_generation, free_slots,   -
//                active_slots, pool_empty, pool_full, pad
//
// each item passes through accept, slot lookup and execute; the result register
// loads at the execute edge. the two dependent memory reads (free ring at the
// head, then the slot's active bit and generation) set these steps.
// a result waiting at m_axis stalls the execute step, and no new beat is
// taken while it waits.
// reset clears pointers and counts at once; no clearing pass over the memories.

module generational_slot_pool_allocator_core
  import gspa_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = POOL_SLOTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // slot_index[6:0], handle_generation[38:7]
  input  logic [CMD_W-1:0]     s_axis_tuser,  // cmd[1:0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata   // ok[0], granted_index[6:1],
                                              // granted_generation[38:7],
                                              // free_slots[45:39], active_slots[52:46],
                                              // pool_empty[53], pool_full[54]
);

  gspa_ctl_t ctl;

  gspa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .ctl_o     (ctl)
  );

  gspa_dpath #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .ctl_i               (ctl),
    .cmd_i               (s_axis_tuser),
    .slot_index_i        (s_axis_tdata[IDX_IN_W-1:0]),
    .handle_generation_i (s_axis_tdata[IDX_IN_W+GEN_W-1:IDX_IN_W]),
    .result_o            (m_axis_tdata)
  );

endmodule

`default_nettype wire
